// ===== hw/rtl/signed_int_to_radix_chars_core_defines.svh =====
// assertion macros for the signed integer to radix text core
// used by the checker bound to the top level; needs nothing else
`ifndef SIGNED_INT_TO_RADIX_CHARS_CORE_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_CHARS_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define SIRC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sirc check failed");

// next-cycle implication, off during reset
`define SIRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sirc check failed");

// next-cycle implication that also covers the reset cycles
`define SIRC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sirc check failed");

`endif

// ===== hw/rtl/sirc_pkg.sv =====
// shared types, constants and character helpers for the radix text core
// no dependencies
`timescale 1ns / 1ps

package sirc_pkg;

   localparam int NUM_W      = 32;   // width of the input number
   localparam int MAX_DIGITS = 32;   // longest digit string (radix 2)
   localparam int DCNT_W     = 6;    // digit count, holds 0..MAX_DIGITS
   localparam int BCNT_W     = 5;    // bit counter of one division
   localparam int LEN_W      = 5;    // base_length register
   localparam int CHARS_W    = 64;   // one digit character register
   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_LOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_HIGH  = 2'd2;

   // register reset values: ten digits "0123456789"
   localparam logic [LEN_W-1:0]   RST_BASE_LENGTH = 5'd10;
   localparam logic [CHARS_W-1:0] RST_CHARS_LOW   = 64'h3736_3534_3332_3130;
   localparam logic [CHARS_W-1:0] RST_CHARS_HIGH  = 64'h0000_0000_0000_3938;

   // characters that may not appear among the digits
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // digit character at position idx of the 16-entry table
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] idx,
                                                    input logic [CHARS_W-1:0] lo,
                                                    input logic [CHARS_W-1:0] hi);
      logic [CHARS_W-1:0] w;
      w = idx[3] ? hi : lo;
      return w[{idx[2:0], 3'b000} +: CHAR_W];
   endfunction

   function automatic logic forbidden_char(input logic [CHAR_W-1:0] c);
      return c inside {CHAR_NUL, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR,
                       CHAR_SPACE, CHAR_PLUS, CHAR_MINUS};
   endfunction

endpackage

// ===== hw/rtl/signed_int_to_radix_chars_core.sv =====
// sequence: accept, then a check of each digit in the table, then a bit-serial
// restoring division per digit, then the text goes out a character at a time, sign first
// intake: one number at a time, a new one only once the core is back to idle
// reset: synchronous, active high; clears control, output valid and loads the
// registers with a ten digit base "0123456789"
`timescale 1ns / 1ps

module signed_int_to_radix_chars_core #(
   parameter int MAX_RADIX = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sirc_pkg::NUM_W-1:0]    req_number,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sirc_pkg::CHAR_W-1:0]          rsp_out_char,
   output logic                                 rsp_last,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sirc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sirc_pkg::CHARS_W-1:0]         csr_wdata
);

   // digit index width, also the width of a remainder
   localparam int DIGIT_W = $clog2(MAX_RADIX);
   localparam int NUM_W   = sirc_pkg::NUM_W;

   // configuration registers
   logic [sirc_pkg::LEN_W-1:0]   base_len_ff;
   logic [sirc_pkg::CHARS_W-1:0] chars_lo_ff;
   logic [sirc_pkg::CHARS_W-1:0] chars_hi_ff;

   // control
   sirc_pkg::state_type state_ff, state_in;

   // datapath
   logic                        neg_ff, neg_in;
   logic [NUM_W-1:0]            quo_ff, quo_in;          // dividend in, quotient out
   logic [DIGIT_W-1:0]          rem_ff, rem_in;
   logic [sirc_pkg::BCNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_W-1:0]          chk_idx_ff, chk_idx_in;
   logic [sirc_pkg::DCNT_W-1:0] ndig_ff, ndig_in;
   logic [DIGIT_W-1:0]          stack_ff [sirc_pkg::MAX_DIGITS];
   logic [DIGIT_W-1:0]          stack_in [sirc_pkg::MAX_DIGITS];

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sirc_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                        rsp_last_ff, rsp_last_in;

   // strobes
   logic req_fire;
   logic out_free;
   logic load_sign;
   logic load_digit;
   logic chk_step;
   logic div_step;

   // check results
   logic [sirc_pkg::CHAR_W-1:0] chk_char;
   logic                        len_bad;
   logic                        chk_dup;
   logic                        chk_bad;
   logic                        chk_last;

   // division step results
   logic [DIGIT_W:0]            div_trial;
   logic                        div_ge;
   logic [DIGIT_W-1:0]          div_rem;
   logic [NUM_W-1:0]            div_quo;
   logic                        div_end;     // last bit of one division
   logic                        div_finish;  // last digit produced

   assign csr_ready = 1'b1;

   assign req_fire = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // --- digit table check: one digit per cycle against all later digits ---
   assign chk_char = sirc_pkg::digit_char(4'(chk_idx_ff), chars_lo_ff, chars_hi_ff);
   assign len_bad  = (base_len_ff < 5'd2) ||
                     (base_len_ff > sirc_pkg::LEN_W'(MAX_RADIX));

   always_comb begin
      chk_dup = 1'b0;
      for (int j = 0; j < MAX_RADIX; j++) begin
         if ((sirc_pkg::LEN_W'(j) > sirc_pkg::LEN_W'(chk_idx_ff)) &&
             (sirc_pkg::LEN_W'(j) < base_len_ff) &&
             (sirc_pkg::digit_char(4'(j), chars_lo_ff, chars_hi_ff) == chk_char)) begin
            chk_dup = 1'b1;
         end
      end
   end

   assign chk_bad  = len_bad || sirc_pkg::forbidden_char(chk_char) || chk_dup;
   assign chk_last = (sirc_pkg::LEN_W'(chk_idx_ff) == (base_len_ff - 5'd1));

   // --- restoring division, one quotient bit per cycle ---
   // remainder stays below the radix, so the trial value fits DIGIT_W+1 bits
   assign div_trial  = {rem_ff, quo_ff[NUM_W-1]};
   assign div_ge     = sirc_pkg::LEN_W'(div_trial) >= base_len_ff;
   assign div_rem    = div_ge ? DIGIT_W'(sirc_pkg::LEN_W'(div_trial) - base_len_ff)
                              : div_trial[DIGIT_W-1:0];
   assign div_quo    = {quo_ff[NUM_W-2:0], div_ge};
   assign div_end    = (bit_cnt_ff == sirc_pkg::BCNT_W'(NUM_W - 1));
   assign div_finish = div_end &&
                       ((div_quo == '0) ||
                        (ndig_ff == sirc_pkg::DCNT_W'(sirc_pkg::MAX_DIGITS - 1)));

   // --- next state ---
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sirc_pkg::ST_IDLE: begin
            if (req_fire) state_in = sirc_pkg::ST_CHECK;
         end
         sirc_pkg::ST_CHECK: begin
            if (chk_bad) state_in = sirc_pkg::ST_IDLE;       // invalid base: no text
            else if (chk_last) state_in = sirc_pkg::ST_DIVIDE;
         end
         sirc_pkg::ST_DIVIDE: begin
            if (div_finish) state_in = neg_ff ? sirc_pkg::ST_SIGN : sirc_pkg::ST_EMIT;
         end
         sirc_pkg::ST_SIGN: begin
            if (out_free) state_in = sirc_pkg::ST_EMIT;
         end
         sirc_pkg::ST_EMIT: begin
            if (out_free && (ndig_ff == sirc_pkg::DCNT_W'(1))) state_in = sirc_pkg::ST_IDLE;
         end
         default: state_in = sirc_pkg::ST_IDLE;
      endcase
   end

   // --- state outputs ---
   always_comb begin
      req_stall  = 1'b1;
      chk_step   = 1'b0;
      div_step   = 1'b0;
      load_sign  = 1'b0;
      load_digit = 1'b0;
      case (state_ff)
         sirc_pkg::ST_IDLE:   req_stall  = 1'b0;
         sirc_pkg::ST_CHECK:  chk_step   = 1'b1;
         sirc_pkg::ST_DIVIDE: div_step   = 1'b1;
         sirc_pkg::ST_SIGN:   load_sign  = out_free;
         sirc_pkg::ST_EMIT:   load_digit = out_free;
         default:             req_stall  = 1'b1;
      endcase
   end

   // --- datapath next values ---
   always_comb begin
      neg_in      = neg_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      bit_cnt_in  = bit_cnt_ff;
      chk_idx_in  = chk_idx_ff;
      ndig_in     = ndig_ff;
      stack_in    = stack_ff;

      if (req_fire) begin
         // magnitude as unsigned, so the most negative value converts too
         neg_in     = req_number[NUM_W-1];
         quo_in     = req_number[NUM_W-1] ? (NUM_W'(0) - NUM_W'(req_number))
                                          : NUM_W'(req_number);
         rem_in     = '0;
         bit_cnt_in = '0;
         chk_idx_in = '0;
         ndig_in    = '0;
      end

      if (chk_step) chk_idx_in = chk_idx_ff + DIGIT_W'(1);

      if (div_step) begin
         quo_in     = div_quo;
         bit_cnt_in = bit_cnt_ff + sirc_pkg::BCNT_W'(1);
         rem_in     = div_rem;
         if (div_end) begin
            // push the new digit; the lowest digit ends up deepest
            rem_in      = '0;
            ndig_in     = ndig_ff + sirc_pkg::DCNT_W'(1);
            stack_in[0] = div_rem;
            for (int k = 1; k < sirc_pkg::MAX_DIGITS; k++) stack_in[k] = stack_ff[k-1];
         end
      end

      if (load_digit) begin
         // pop toward the top
         ndig_in = ndig_ff - sirc_pkg::DCNT_W'(1);
         for (int k = 0; k < sirc_pkg::MAX_DIGITS - 1; k++) stack_in[k] = stack_ff[k+1];
         stack_in[sirc_pkg::MAX_DIGITS-1] = '0;
      end
   end

   // --- output register ---
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = sirc_pkg::CHAR_MINUS;
         rsp_last_in  = 1'b0;
      end else if (load_digit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = sirc_pkg::digit_char(4'(stack_ff[0]), chars_lo_ff, chars_hi_ff);
         rsp_last_in  = (ndig_ff == sirc_pkg::DCNT_W'(1));
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sirc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         base_len_ff  <= sirc_pkg::RST_BASE_LENGTH;
         chars_lo_ff  <= sirc_pkg::RST_CHARS_LOW;
         chars_hi_ff  <= sirc_pkg::RST_CHARS_HIGH;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sirc_pkg::CSR_BASE_LENGTH: base_len_ff <= csr_wdata[sirc_pkg::LEN_W-1:0];
               sirc_pkg::CSR_CHARS_LOW:   chars_lo_ff <= csr_wdata;
               sirc_pkg::CSR_CHARS_HIGH:  chars_hi_ff <= csr_wdata;
               default: ;   // unused index, write dropped
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      bit_cnt_ff  <= bit_cnt_in;
      chk_idx_ff  <= chk_idx_in;
      ndig_ff     <= ndig_in;
      stack_ff    <= stack_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== hw/rtl/sirc_checker.sv =====
// port-level checks for the radix text core, bound to the top level
// depends on sirc_pkg and signed_int_to_radix_chars_core_defines.svh
`timescale 1ns / 1ps
`include "signed_int_to_radix_chars_core_defines.svh"

module sirc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [sirc_pkg::CHAR_W-1:0]     rsp_out_char,
   input logic                            rsp_last
);

   logic sign_shown;

   assign sign_shown = rsp_valid && (rsp_out_char == sirc_pkg::CHAR_MINUS);

   // one item at a time: intake closes right after an accept
   `SIRC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // the sign never closes a number's text
   `SIRC_ASSERT_IMPL(a_sign_not_last, clock, reset, sign_shown, !rsp_last)

   // a stalled item stays offered
   `SIRC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // nothing offered right after reset
   `SIRC_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

endmodule

bind signed_int_to_radix_chars_core sirc_checker u_sirc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_char (rsp_out_char),
   .rsp_last     (rsp_last)
);

// ===== dv/radix_text_checker.sv =====
// checker for the signed integer to radix text core: follows the register writes,
// predicts the text of each accepted number and compares every sent character
// depends on sirc_pkg for widths, register indexes and character codes
`timescale 1ns / 1ps

module radix_text_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [sirc_pkg::NUM_W-1:0] req_number,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [sirc_pkg::CHAR_W-1:0]       rsp_out_char,
   input  logic                              rsp_last,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [sirc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sirc_pkg::CHARS_W-1:0]      csr_wdata,
   output int                                error_count,
   output int                                pending_chars
);

   localparam int RADIX_LIMIT = 16;

   typedef struct packed {
      logic [sirc_pkg::CHAR_W-1:0] ch;
      logic                        last;
   } text_char_type;

   text_char_type                expected_text[$];
   logic [sirc_pkg::LEN_W-1:0]   radix_len;
   logic [sirc_pkg::CHARS_W-1:0] chars_lo;
   logic [sirc_pkg::CHARS_W-1:0] chars_hi;

   function automatic logic [sirc_pkg::CHAR_W-1:0] table_entry(input int idx);
      logic [2*sirc_pkg::CHARS_W-1:0] tbl;
      tbl = {chars_hi, chars_lo};
      return tbl[(idx & 15) * sirc_pkg::CHAR_W +: sirc_pkg::CHAR_W];
   endfunction

   function automatic bit is_blocked(input logic [sirc_pkg::CHAR_W-1:0] c);
      case (c)
         sirc_pkg::CHAR_NUL, sirc_pkg::CHAR_TAB, sirc_pkg::CHAR_LF, sirc_pkg::CHAR_VT,
         sirc_pkg::CHAR_FF, sirc_pkg::CHAR_CR, sirc_pkg::CHAR_SPACE, sirc_pkg::CHAR_PLUS,
         sirc_pkg::CHAR_MINUS: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit radix_usable();
      int i;
      int j;
      if (radix_len < 2 || radix_len > RADIX_LIMIT) return 1'b0;
      for (i = 0; i < radix_len; i++)
         if (is_blocked(table_entry(i))) return 1'b0;
      for (i = 0; i < radix_len; i++)
         for (j = i + 1; j < radix_len; j++)
            if (table_entry(i) == table_entry(j)) return 1'b0;
      return 1'b1;
   endfunction

   task automatic flag_error(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // digits come out least significant first, so collect then push in reverse
   task automatic predict_text(input logic signed [sirc_pkg::NUM_W-1:0] number);
      logic [sirc_pkg::NUM_W-1:0]  mag;
      logic [sirc_pkg::NUM_W-1:0]  radix;
      logic [sirc_pkg::CHAR_W-1:0] rev[sirc_pkg::MAX_DIGITS];
      int                          ndig;
      int                          k;
      if (!radix_usable()) return;
      radix = sirc_pkg::NUM_W'(radix_len);
      mag   = number[sirc_pkg::NUM_W-1] ? (~$unsigned(number)) + 1'b1 : $unsigned(number);
      ndig  = 0;
      do begin
         rev[ndig] = table_entry(int'(mag % radix));
         ndig++;
         mag = mag / radix;
      end while (mag != 0 && ndig < sirc_pkg::MAX_DIGITS);
      if (number[sirc_pkg::NUM_W-1])
         expected_text.push_back('{ch: sirc_pkg::CHAR_MINUS, last: 1'b0});
      for (k = ndig - 1; k >= 0; k--)
         expected_text.push_back('{ch: rev[k], last: (k == 0)});
   endtask

   always @(posedge clock) begin : watch
      text_char_type want;
      if (reset) begin
         radix_len = sirc_pkg::RST_BASE_LENGTH;
         chars_lo  = sirc_pkg::RST_CHARS_LOW;
         chars_hi  = sirc_pkg::RST_CHARS_HIGH;
         expected_text.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               flag_error($sformatf("unexpected char 0x%02h last %0b",
                                    rsp_out_char, rsp_last));
            end else begin
               want = expected_text.pop_front();
               if (rsp_out_char !== want.ch)
                  flag_error($sformatf("char 0x%02h, want 0x%02h", rsp_out_char, want.ch));
               if (rsp_last !== want.last)
                  flag_error($sformatf("last %0b, want %0b on char 0x%02h",
                                       rsp_last, want.last, want.ch));
            end
         end
         if (req_valid && !req_stall)
            predict_text(req_number);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sirc_pkg::CSR_BASE_LENGTH: radix_len = csr_wdata[sirc_pkg::LEN_W-1:0];
               sirc_pkg::CSR_CHARS_LOW:   chars_lo  = csr_wdata;
               sirc_pkg::CSR_CHARS_HIGH:  chars_hi  = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_chars = expected_text.size();
   end

endmodule

// ===== dv/testbench.sv =====
// top of the radix text core testbench: clock, reset, stimulus and verdict
// depends on sirc_pkg, signed_int_to_radix_chars_core and radix_text_checker
`timescale 1ns / 1ps

module testbench;

   // above the worst case of one number, rounded up generously
   localparam int SETTLE_CYCLES = 1200;
   // receiver hold-off long enough that the core fills and stalls its input
   localparam int LONG_HOLD     = 2000;
   // random items wanted on valid bases
   localparam int RANDOM_ITEMS  = 205;
   // unused register index, writes to it must be ignored
   localparam logic [sirc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;
   typedef enum int {NUM_FULL, NUM_SMALL, NUM_EDGE, NUM_SCALED} num_kind_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [sirc_pkg::NUM_W-1:0] req_number = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [sirc_pkg::CHAR_W-1:0]       rsp_out_char;
   logic                              rsp_last;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [sirc_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [sirc_pkg::CHARS_W-1:0]      csr_wdata = '0;

   int   error_count;
   int   pending_chars;
   logic hold_toggle = 1'b0;   // flipped by the stimulus to ask for a long hold-off
   int   burst_left  = 0;

   always #1 clock = ~clock;

   signed_int_to_radix_chars_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   radix_text_checker text_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_number    (req_number),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_chars (pending_chars)
   );

   // numbers mix full range, small values, extremes and scaled magnitudes
   function automatic logic signed [sirc_pkg::NUM_W-1:0] random_number();
      logic signed [sirc_pkg::NUM_W-1:0] v;
      int                                pick;
      num_kind_type                      kind;
      pick = $urandom_range(0, 5);
      if (pick > 3) pick = 0;
      kind = num_kind_type'(pick);
      case (kind)
         NUM_SMALL: v = int'($urandom_range(0, 200)) - 100;
         NUM_EDGE: begin
            case ($urandom_range(0, 5))
               0: v = 32'sh8000_0000;
               1: v = 32'sh7FFF_FFFF;
               2: v = -1;
               3: v = 0;
               4: v = 1;
               default: v = 32'sh8000_0001;
            endcase
         end
         NUM_SCALED: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // distinct legal digits in use; bytes above the length are left random
   task automatic random_digit_table(input int len,
                                     output logic [sirc_pkg::CHARS_W-1:0] lo,
                                     output logic [sirc_pkg::CHARS_W-1:0] hi);
      logic [2*sirc_pkg::CHARS_W-1:0] tbl;
      logic [sirc_pkg::CHAR_W-1:0]    c;
      bit                             taken[256];
      int                             i;
      tbl = {$urandom, $urandom, $urandom, $urandom};
      for (i = 0; i < len; i++) begin
         // everything above the minus sign is a legal digit
         do c = sirc_pkg::CHAR_W'($urandom_range(8'h2E, 8'hFF)); while (taken[c]);
         taken[c] = 1'b1;
         tbl[i * sirc_pkg::CHAR_W +: sirc_pkg::CHAR_W] = c;
      end
      lo = tbl[sirc_pkg::CHARS_W-1:0];
      hi = tbl[2*sirc_pkg::CHARS_W-1:sirc_pkg::CHARS_W];
   endtask

   // offer one item and hold it until accepted; leaves valid high on return
   task automatic send_number(input logic signed [sirc_pkg::NUM_W-1:0] n);
      req_valid  <= 1'b1;
      req_number <= n;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // sender pause until every predicted char has been sent
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_chars != 0);
   endtask

   // the core may still be busy on an item with no text, give it its full latency
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register write; valid stays high so back to back writes need no gap
   task automatic csr_write(input logic [sirc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sirc_pkg::CHARS_W-1:0]   data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // all three registers are written each time, only while the core is idle
   task automatic apply_config(input int len, input logic [sirc_pkg::CHARS_W-1:0] lo,
                               input logic [sirc_pkg::CHARS_W-1:0] hi);
      logic [sirc_pkg::CHARS_W-1:0] len_word;
      settle();
      len_word = {$urandom, $urandom};   // upper bits are don't-care, toggle them anyway
      len_word[sirc_pkg::LEN_W-1:0] = sirc_pkg::LEN_W'(len);
      csr_write(sirc_pkg::CSR_BASE_LENGTH, len_word);
      csr_write(sirc_pkg::CSR_CHARS_LOW, lo);
      csr_write(sirc_pkg::CSR_CHARS_HIGH, hi);
      csr_valid <= 1'b0;
   endtask

   // a batch of random numbers, either in bursts with gaps or back to back
   task automatic send_batch(input int count, input bit bursty);
      int i;
      for (i = 0; i < count; i++) begin
         if (bursty && burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            burst_left = $urandom_range(1, 6);
         end
         send_number(random_number());
         if (burst_left > 0) burst_left--;
      end
   endtask

   // receiver stall pattern: random modes in stretches, plus a long hold on request
   initial begin : rsp_pattern
      stall_mode_type mode;
      int             mode_left;
      int             hold_left;
      logic           seen_toggle;
      mode        = STALL_NONE;
      mode_left   = 0;
      hold_left   = 0;
      seen_toggle = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 9) < 6);
               STALL_TOGGLE: rsp_stall <= ~rsp_stall;
               default:      rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // timeout, far above the slowest correct run
   initial begin : watchdog
      #4_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [sirc_pkg::CHAR_W-1:0]    blocked[9];
      logic [2*sirc_pkg::CHARS_W-1:0] tbl;
      logic [sirc_pkg::CHARS_W-1:0]   lo;
      logic [sirc_pkg::CHARS_W-1:0]   hi;
      int                             k;
      int                             pos;
      int                             counted;
      int                             phase;
      int                             len;
      int                             n;

      blocked = '{sirc_pkg::CHAR_NUL, sirc_pkg::CHAR_TAB, sirc_pkg::CHAR_LF,
                  sirc_pkg::CHAR_VT, sirc_pkg::CHAR_FF, sirc_pkg::CHAR_CR,
                  sirc_pkg::CHAR_SPACE, sirc_pkg::CHAR_PLUS, sirc_pkg::CHAR_MINUS};

      // hold reset once at the start, then release it
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset base is decimal: zero, one digit, digit rollover, both extremes
      send_number(0);
      send_number(1);
      send_number(-1);
      send_number(9);
      send_number(10);
      send_number(-10);
      send_number(32'sh7FFF_FFFF);
      send_number(32'sh8000_0000);   // most negative goes through unsigned magnitude
      send_number(1_000_000_000);

      // binary: the longest text, 32 digits plus sign
      apply_config(2, 64'h3130, 64'h0);
      send_number(0);
      send_number(-1);
      send_number(32'sh8000_0000);
      send_number(32'sh7FFF_FFFF);
      send_number(6);

      // sixteen digits, the largest radix
      apply_config(16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
      send_number(32'shDEAD_BEEF);
      send_number(255);
      send_number(-256);

      // write to the unused index must leave the hex base alone
      settle();
      csr_write(CSR_UNUSED, {$urandom, $urandom});
      csr_valid <= 1'b0;
      send_number(random_number());
      send_number(random_number());

      // length too short or above the radix limit gives no text
      apply_config(0, sirc_pkg::RST_CHARS_LOW, sirc_pkg::RST_CHARS_HIGH);
      send_number(random_number());
      apply_config(1, sirc_pkg::RST_CHARS_LOW, sirc_pkg::RST_CHARS_HIGH);
      send_number(random_number());
      apply_config(17, 64'h3736_3534_3332_3130, 64'h4746_4544_4342_4138);
      send_number(random_number());
      apply_config(31, 64'h3736_3534_3332_3130, 64'h4746_4544_4342_4138);
      send_number(random_number());

      // each forbidden character among the digits in use, edges of the range too
      for (k = 0; k < 9; k++) begin
         tbl = {sirc_pkg::RST_CHARS_HIGH, sirc_pkg::RST_CHARS_LOW};
         pos = (k == 0) ? 9 : (k == 1) ? 0 : $urandom_range(0, 9);
         tbl[pos * sirc_pkg::CHAR_W +: sirc_pkg::CHAR_W] = blocked[k];
         apply_config(10, tbl[sirc_pkg::CHARS_W-1:0],
                      tbl[2*sirc_pkg::CHARS_W-1:sirc_pkg::CHARS_W]);
         send_number(random_number());
      end

      // repeated digit in use gives no text
      tbl = {sirc_pkg::RST_CHARS_HIGH, sirc_pkg::RST_CHARS_LOW};
      tbl[9 * sirc_pkg::CHAR_W +: sirc_pkg::CHAR_W] = tbl[sirc_pkg::CHAR_W-1:0];
      apply_config(10, tbl[sirc_pkg::CHARS_W-1:0],
                   tbl[2*sirc_pkg::CHARS_W-1:sirc_pkg::CHARS_W]);
      send_number(random_number());

      // forbidden and repeated bytes above the length do not matter
      tbl = {sirc_pkg::RST_CHARS_HIGH, sirc_pkg::RST_CHARS_LOW};
      tbl[12 * sirc_pkg::CHAR_W +: sirc_pkg::CHAR_W] = sirc_pkg::CHAR_MINUS;
      tbl[13 * sirc_pkg::CHAR_W +: sirc_pkg::CHAR_W] =
         tbl[5 * sirc_pkg::CHAR_W +: sirc_pkg::CHAR_W];
      tbl[14 * sirc_pkg::CHAR_W +: sirc_pkg::CHAR_W] =
         tbl[5 * sirc_pkg::CHAR_W +: sirc_pkg::CHAR_W];
      apply_config(10, tbl[sirc_pkg::CHARS_W-1:0],
                   tbl[2*sirc_pkg::CHARS_W-1:sirc_pkg::CHARS_W]);
      send_number(-987654321);
      send_number(random_number());

      // random phases, each with its own base
      counted = 0;
      phase   = 0;
      while (counted < RANDOM_ITEMS) begin
         if (phase % 6 == 3) begin
            // raw register contents, valid or not, text or none
            apply_config($urandom_range(0, 31), {$urandom, $urandom}, {$urandom, $urandom});
            send_batch(6, 1'b1);
         end else begin
            // short bases are slow, keep them rare and their batches small
            if (phase % 7 == 0) begin
               len = $urandom_range(2, 4);
               n   = 6;
            end else begin
               len = $urandom_range(5, 16);
               n   = $urandom_range(12, 28);
            end
            random_digit_table(len, lo, hi);
            apply_config(len, lo, hi);
            if (phase == 2) begin
               // long receiver hold-off while items keep coming
               hold_toggle <= ~hold_toggle;
               send_batch(n, 1'b0);
            end else if (phase == 5) begin
               // pause halfway until the text so far is all out
               send_batch(n / 2, 1'b1);
               wait_drained();
               send_batch(n - n / 2, 1'b1);
            end else begin
               send_batch(n, phase % 3 != 1);
            end
            counted += n;
         end
         phase++;
      end

      // let everything come out, then the verdict
      settle();
      if (error_count == 0 && pending_chars == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== signed_int_to_radix_chars_core.f =====
+incdir+hw/rtl
hw/rtl/sirc_pkg.sv
hw/rtl/signed_int_to_radix_chars_core.sv
hw/rtl/sirc_checker.sv
dv/radix_text_checker.sv
dv/testbench.sv
